// File: rtl/core/nmea_pkg.sv
// Shared constants and result type for the NMEA RMC sentence framer.
package nmea_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 7;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 7'd75;
    localparam logic [INDEX_W-1:0] HEADER_END = 7'd5;
    localparam logic [INDEX_W-1:0] POS_FIRST  = 7'd0;
    localparam logic [INDEX_W-1:0] POS_FIFTH  = 7'd4;
    localparam logic [INDEX_W-1:0] POS_SIXTH  = 7'd5;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

    typedef struct packed {
        logic               wrote;
        logic [INDEX_W-1:0] write_index;
        logic [BYTE_W-1:0]  write_value;
        logic               frame_done;
        logic [INDEX_W-1:0] frame_length;
    } nmea_result_t;

endpackage

// File: rtl/core/nmea_frm_track.sv
// Line position tracker: header capture, RMC filter, frame completion and clamp.
module nmea_frm_track
    import nmea_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [BYTE_W-1:0]   byte_in,
    output nmea_result_t        result
);

    logic [INDEX_W-1:0] count_reg;
    logic [INDEX_W-1:0] count_next;
    logic [BYTE_W-1:0]  first_reg;
    logic [BYTE_W-1:0]  first_next;
    logic [BYTE_W-1:0]  fifth_reg;
    logic [BYTE_W-1:0]  fifth_next;
    logic [BYTE_W-1:0]  sixth_reg;
    logic [BYTE_W-1:0]  sixth_next;
    logic [INDEX_W-1:0] count_in;
    logic [INDEX_W-1:0] count_inc;
    logic               is_rmc;

    assign count_in  = (byte_in == CH_DOLLAR) ? '0 : count_reg;
    assign count_inc = count_in + INDEX_W'(1);
    assign is_rmc    = (first_reg == CH_DOLLAR) && (fifth_reg == CH_M) && (sixth_reg == CH_C);

    always_comb
    begin
        result     = '0;
        count_next = count_in;
        first_next = first_reg;
        fifth_next = fifth_reg;
        sixth_next = sixth_reg;
        if (count_in <= HEADER_END)
        begin
            if (count_in == POS_FIRST)
                first_next = byte_in;
            if (count_in == POS_FIFTH)
                fifth_next = byte_in;
            if (count_in == POS_SIXTH)
                sixth_next = byte_in;
            result.wrote       = 1'b1;
            result.write_index = count_in;
            result.write_value = byte_in;
            count_next         = count_inc;
        end
        else if (is_rmc)
        begin
            result.wrote       = 1'b1;
            result.write_index = count_in;
            result.write_value = byte_in;
            if (byte_in == CH_NL)
            begin
                result.frame_done   = 1'b1;
                result.frame_length = count_inc;
                count_next          = '0;
                first_next          = '0;
                fifth_next          = '0;
                sixth_next          = '0;
            end
            else if (count_inc >= LAST_INDEX)
            begin
                count_next = LAST_INDEX;
                if (count_in == LAST_INDEX)
                    result.write_value = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (step)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            first_reg <= first_next;
            fifth_reg <= fifth_next;
            sixth_reg <= sixth_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_INDEX)
        else $error("line position beyond last index");

    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done |=> count_reg == '0)
        else $error("position not restarted after frame");

    a_done_length: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done |->
            result.wrote && (result.frame_length == result.write_index + INDEX_W'(1)))
        else $error("frame length does not match newline position");

    a_dollar_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && (byte_in == CH_DOLLAR) |-> result.wrote && (result.write_index == '0))
        else $error("dollar did not restart the line");

endmodule

// File: rtl/core/nmea_frm_outreg.sv
// Result register holding one transaction until the receiver takes it.
module nmea_frm_outreg
    import nmea_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  nmea_result_t  result_in,
    input  logic          out_ready,
    output logic          out_valid,
    output logic          free,
    output nmea_result_t  result_out
);

    logic         valid_reg;
    nmea_result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register overwritten while held");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled result changed");

endmodule

// File: rtl/core/nmea_rmc_sentence_framer.sv
// Top level of the NMEA RMC sentence framer: input register, tracker, result register.
//
// Input channel: in_valid / in_ready carry one received GPS character, rx_byte,
// per transaction. Output channel: out_valid / out_ready carry one result per
// character: wrote, write_index and write_value describe the line store write
// (all zero when the character is dropped), frame_done and frame_length report
// a completed RMC sentence.
// A character taken into the input register is processed by the tracker and loaded
// into the result register, which presents its result until the receiver takes it.
// Throughput: one character per cycle while the receiver does not stall, set by the
// combinational compare and count step between the input and result registers.
// Reset clears the line position and both valid flags; the header copies are not
// reset and are rebuilt from the characters at line positions 0, 4 and 5.
// When the receiver stalls, the result register holds its transaction, the
// input register holds one more character, and in_ready drops until the
// receiver takes the held result.
module nmea_rmc_sentence_framer
    import nmea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               wrote,
    output logic [INDEX_W-1:0] write_index,
    output logic [BYTE_W-1:0]  write_value,
    output logic               frame_done,
    output logic [INDEX_W-1:0] frame_length
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_free;
    logic              advance;
    nmea_result_t      step_result;
    nmea_result_t      held_result;

    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= rx_byte;
    end

    nmea_frm_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (byte_reg),
        .result  (step_result)
    );

    nmea_frm_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (step_result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .free       (out_free),
        .result_out (held_result)
    );

    assign wrote        = held_result.wrote;
    assign write_index  = held_result.write_index;
    assign write_value  = held_result.write_value;
    assign frame_done   = held_result.frame_done;
    assign frame_length = held_result.frame_length;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(byte_reg))
        else $error("held character lost while result stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> in_valid_reg)
        else $error("accepted character not registered");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled with empty register");

endmodule
